### rtl/rc4_pkg.sv
// rc4 keystream cipher: shared types and constants
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int KEY_LEN_W  = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TABLE_SIZE = 256;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_WORD0 = 3'd1;

  localparam logic REQ_KEY   = 1'b0;
  localparam logic REQ_DATA  = 1'b1;
  localparam logic RESP_KEY  = 1'b0;
  localparam logic RESP_DATA = 1'b1;

  typedef struct packed {
    logic accept;
    logic fill;
    logic step_a;
    logic step_b;
    logic wr_a;
    logic wr_b;
    logic adv;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
    logic key_op;
  } sts_t;

endpackage

### rtl/rc4_ctrl.sv
// rc4 keystream cipher: sequencing state machine
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tuser,
  output logic          in_tready,
  input  rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B
  } state_t;

  state_t state_r, state_nxt;
  logic   rekey_r, rekey_nxt;
  logic   ready_r;
  logic   last_step;

  assign in_tready = ready_r;
  assign last_step = !sts.key_op || sts.cnt_last;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    rekey_nxt  = rekey_r;
    unique case (state_r)
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = rekey_r ? ST_RD_A : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ready_r && in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_tuser == rc4_pkg::REQ_KEY) begin
            state_nxt = ST_FILL;
            rekey_nxt = 1'b1;
          end else begin
            state_nxt = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        cmd.step_a = 1'b1;
        state_nxt  = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.step_b = 1'b1;
        state_nxt  = ST_WR_A;
      end
      ST_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        cmd.wr_b = 1'b1;
        if (!last_step) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_RD_A;
        end else if (sts.out_free) begin
          cmd.adv   = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
          rekey_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      rekey_r <= 1'b0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rekey_r <= rekey_nxt;
      ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

### rtl/rc4_dp.sv
// rc4 keystream cipher: permutation memory, indices, key registers and output register
`timescale 1ns / 1ps

module rc4_dp #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [rc4_pkg::BYTE_W-1:0]       in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  rc4_pkg::cmd_t                    cmd,
  output rc4_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rc4_pkg::BYTE_W-1:0]       out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int KP_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [rc4_pkg::BYTE_W-1:0]    mem [rc4_pkg::TABLE_SIZE];
  logic [rc4_pkg::BYTE_W-1:0]    key_r [MAX_KEY_BYTES];
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_r;
  logic [rc4_pkg::KEY_LEN_W-1:0] len_m1;
  logic [KP_W-1:0]               kp_r;
  logic                          kp_last;

  logic [rc4_pkg::BYTE_W-1:0] i_r, j_r, cnt_r, acc_r;
  logic [rc4_pkg::BYTE_W-1:0] a_r, b_r, sa_r, sb_r, t_r;
  logic [rc4_pkg::BYTE_W-1:0] rda_r, rdb_r;
  logic                       kind_r, last_r;
  logic [rc4_pkg::BYTE_W-1:0] din_r;

  logic                       out_valid_r;
  logic [rc4_pkg::BYTE_W-1:0] out_data_r;
  logic                       out_kind_r, out_last_r;

  logic                       key_op;
  logic [rc4_pkg::BYTE_W-1:0] a_nxt, base, key_add, b_sum, t_sum, ks;
  logic [rc4_pkg::BYTE_W-1:0] ra, rb, wa, wd;
  logic                       we;

  assign key_op = (kind_r == rc4_pkg::REQ_KEY);

  // effective key length minus one
  always_comb begin
    priority if (key_len_r == '0) begin
      len_m1 = '0;
    end else if (key_len_r > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      len_m1 = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES - 1);
    end else begin
      len_m1 = key_len_r - 1'b1;
    end
  end

  assign kp_last = (rc4_pkg::KEY_LEN_W'(kp_r) == len_m1);

  always_comb begin
    a_nxt   = key_op ? cnt_r : i_r + 1'b1;
    base    = key_op ? acc_r : j_r;
    key_add = key_op ? key_r[kp_r] : '0;
    b_sum   = base + rda_r + key_add;
    t_sum   = sa_r + rdb_r;
    ra      = a_nxt;
    priority if (cmd.step_b) begin
      rb = b_sum;
    end else if (cmd.wr_a) begin
      rb = t_sum;
    end else begin
      rb = t_r;
    end
    // only entries a and b change during a swap
    priority if (t_r == b_r) begin
      ks = sa_r;
    end else if (t_r == a_r) begin
      ks = sb_r;
    end else begin
      ks = rdb_r;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = cnt_r;
    priority if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.wr_a) begin
      we = 1'b1;
      wa = a_r;
      wd = rdb_r;
    end else if (cmd.wr_b) begin
      we = 1'b1;
      wa = b_r;
      wd = sa_r;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= rc4_pkg::KEY_LEN_W'(1);
      for (int k = 0; k < MAX_KEY_BYTES; k++) begin
        key_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_addr == rc4_pkg::REG_KEY_LEN) begin
        key_len_r <= cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
      end
      for (int k = 0; k < MAX_KEY_BYTES; k++) begin
        if (cfg_addr == rc4_pkg::REG_KEY_WORD0 + rc4_pkg::CFG_ADDR_W'(k >> 3)) begin
          key_r[k] <= cfg_wdata[8*(k & 7) +: rc4_pkg::BYTE_W];
        end
      end
    end
  end

  // step datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser;
      din_r  <= in_tdata;
      last_r <= in_tlast;
      if (in_tuser == rc4_pkg::REQ_KEY) begin
        acc_r <= '0;
        kp_r  <= '0;
      end
    end
    if (cmd.step_a) begin
      a_r <= a_nxt;
    end
    if (cmd.step_b) begin
      b_r  <= b_sum;
      sa_r <= rda_r;
    end
    if (cmd.wr_a) begin
      sb_r <= rdb_r;
      t_r  <= t_sum;
    end
    if (cmd.adv && key_op) begin
      acc_r <= b_r;
      kp_r  <= kp_last ? '0 : kp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r   <= '0;
      j_r   <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.accept && in_tuser == rc4_pkg::REQ_KEY) begin
        cnt_r <= '0;
      end else if (cmd.fill) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.adv && key_op) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.adv) begin
        if (!key_op) begin
          i_r <= a_r;
          j_r <= b_r;
        end else if (sts.cnt_last) begin
          i_r <= '0;
          j_r <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= key_op ? '0 : (din_r ^ ks);
      out_kind_r <= key_op ? rc4_pkg::RESP_KEY : rc4_pkg::RESP_DATA;
      out_last_r <= key_op ? 1'b0 : last_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_kind_r;
  assign out_tlast    = out_last_r;

  assign sts.cnt_last = (cnt_r == rc4_pkg::BYTE_MAX);
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.key_op   = key_op;

endmodule

### rtl/rc4_keystream_cipher.sv
// rc4 keystream cipher: top level
//
//   channel  direction  tdata             tuser           tlast
//   in_      slave      [7:0] data_in     [0] req_type    last_in
//   out_     master     [7:0] data_out    [0] resp_kind   last_out
//   cfg_     write      [63:0] value, cfg_addr = register index 0..4
//
// a data beat runs from acceptance to result through one read of s[i],
// one of s[j], then two swap writes through the single memory write port.
// a rekey beat runs an identity fill, then 256 swap steps that each pass
// through the same read and write states as a data beat.
// after reset a fill loads the identity permutation; in_tready stays low.
// a finished result waiting on out_tready holds the last step; a new beat is
// taken while the result register is still full.
`timescale 1ns / 1ps

module rc4_keystream_cipher #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_in
  input  logic                           in_tuser,   // req_type
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // data_out
  output logic                           out_tuser,  // resp_kind
  output logic                           out_tlast
);

  rc4_pkg::cmd_t cmd;
  rc4_pkg::sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_reset_fill : assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("in_tready high straight after reset");

  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwrote a beat not yet taken");

  a_one_step : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fill, cmd.step_a, cmd.step_b, cmd.wr_a, cmd.wr_b, cmd.accept}))
    else $error("more than one datapath step at once");

  a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while busy");

endmodule

### dv/tb_rc4_keystream_cipher.sv
// self-checking testbench for the rc4 keystream cipher with a predicting scoreboard
`timescale 1ns / 1ps

module tb_rc4_keystream_cipher;

  localparam int MAX_KEY_BYTES = 32;
  localparam int RANDOM_BEATS  = 1425;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REKEY_CYCLES  = 1300;

  localparam logic [rc4_pkg::CFG_ADDR_W-1:0] REG_KEY_WORD1 = rc4_pkg::REG_KEY_WORD0 + 3'd1;
  localparam logic [rc4_pkg::CFG_ADDR_W-1:0] REG_KEY_WORD2 = rc4_pkg::REG_KEY_WORD0 + 3'd2;
  localparam logic [rc4_pkg::CFG_ADDR_W-1:0] REG_KEY_WORD3 = rc4_pkg::REG_KEY_WORD0 + 3'd3;
  localparam logic [rc4_pkg::CFG_ADDR_W-1:0] REG_UNUSED_LO = rc4_pkg::REG_KEY_WORD0 + 3'd4;
  localparam logic [rc4_pkg::CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [rc4_pkg::CFG_DATA_W-1:0] ALL_ONES = {rc4_pkg::CFG_DATA_W{1'b1}};

  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] data;
    logic                       kind;
    logic                       last;
  } cipher_beat_t;

  class keystream_tracker;
    logic [rc4_pkg::BYTE_W-1:0]     perm [rc4_pkg::TABLE_SIZE];
    logic [rc4_pkg::BYTE_W-1:0]     idx_i;
    logic [rc4_pkg::BYTE_W-1:0]     idx_j;
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;
    logic [rc4_pkg::CFG_DATA_W-1:0] key_word [4];
    cipher_beat_t                   expected_q [$];
    int                             errors;

    function new();
      fill_identity();
      idx_i   = '0;
      idx_j   = '0;
      key_len = 6'd1;
      foreach (key_word[w]) key_word[w] = '0;
      errors  = 0;
    endfunction

    function void fill_identity();
      for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++) perm[k] = k[rc4_pkg::BYTE_W-1:0];
    endfunction

    function void write_reg(logic [rc4_pkg::CFG_ADDR_W-1:0] addr,
                            logic [rc4_pkg::CFG_DATA_W-1:0] value);
      case (addr)
        rc4_pkg::REG_KEY_LEN:   key_len = value[rc4_pkg::KEY_LEN_W-1:0];
        rc4_pkg::REG_KEY_WORD0,
        REG_KEY_WORD1,
        REG_KEY_WORD2,
        REG_KEY_WORD3: key_word[int'(addr - rc4_pkg::REG_KEY_WORD0)] = value;
        default: ;
      endcase
    endfunction

    function void swap_entries(logic [rc4_pkg::BYTE_W-1:0] a, logic [rc4_pkg::BYTE_W-1:0] b);
      logic [rc4_pkg::BYTE_W-1:0] tmp;
      tmp     = perm[a];
      perm[a] = perm[b];
      perm[b] = tmp;
    endfunction

    function void run_key_schedule();
      int                         n;
      logic [rc4_pkg::BYTE_W-1:0] acc;
      logic [rc4_pkg::BYTE_W-1:0] kb;
      n = key_len;
      if (n == 0) n = 1;
      if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
      fill_identity();
      acc = '0;
      for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++) begin
        kb  = key_word[(k % n) / 8][8 * ((k % n) % 8) +: 8];
        acc = acc + perm[k] + kb;
        swap_entries(k[rc4_pkg::BYTE_W-1:0], acc);
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void note_beat(logic req, logic [rc4_pkg::BYTE_W-1:0] din, logic last);
      cipher_beat_t               r;
      logic [rc4_pkg::BYTE_W-1:0] t;
      if (req == rc4_pkg::REQ_KEY) begin
        run_key_schedule();
        r = '{data: '0, kind: rc4_pkg::RESP_KEY, last: 1'b0};
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        swap_entries(idx_i, idx_j);
        t = perm[idx_i] + perm[idx_j];
        r = '{data: din ^ perm[t], kind: rc4_pkg::RESP_DATA, last: last};
      end
      expected_q.push_back(r);
    endfunction

    function void check_beat(logic [rc4_pkg::BYTE_W-1:0] data, logic kind, logic last);
      cipher_beat_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: data_out %0h resp_kind %0b", data, kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $error("data_out: expected %0h, got %0h", e.data, data);
        errors++;
      end
      if (kind !== e.kind) begin
        $error("resp_kind: expected %0b, got %0b", e.kind, kind);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rc4_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // data_in
  logic                           in_tuser;   // req_type
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // data_out
  logic                           out_tuser;  // resp_kind
  logic                           out_tlast;

  keystream_tracker tracker;
  int unsigned      gap_max;
  int unsigned      stall_max;
  int               cycle_count;
  int               random_sent;

  rc4_keystream_cipher #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // caller lowers cfg_we once a run of writes is done
  task automatic write_reg(logic [rc4_pkg::CFG_ADDR_W-1:0] addr,
                           logic [rc4_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    tracker.write_reg(addr, value);
    @(posedge clk);
  endtask

  task automatic send_beat(logic req, logic [7:0] din, logic last);
    int unsigned gap;
    gap = $urandom_range(gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= din;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tracker.note_beat(req, din, last);
  endtask

  task automatic send_data(int count);
    for (int n = 0; n < count; n++)
      send_beat(rc4_pkg::REQ_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic collect_results();
    int unsigned stall;
    forever begin
      stall = $urandom_range(stall_max);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_beat(out_tdata, out_tuser, out_tlast);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [rc4_pkg::CFG_DATA_W-1:0] pick_key_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [rc4_pkg::CFG_DATA_W-1:0] len_word;
    int                             beats;
    tracker     = new();
    cycle_count = 0;
    random_sent = 0;
    gap_max     = 8;
    stall_max   = 8;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= rc4_pkg::REQ_DATA;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none
    do @(posedge clk); while (!in_tready);

    // identity permutation before any rekey, first step hits equal indices; then a rekey and more data
    send_beat(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_beat(rc4_pkg::REQ_DATA, 8'hFF, 1'b1);
    send_beat(rc4_pkg::REQ_DATA, 8'h5A, 1'b0);
    send_beat(rc4_pkg::REQ_KEY, 8'hFF, 1'b1);
    send_beat(rc4_pkg::REQ_DATA, 8'hFF, 1'b1);
    send_beat(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    wait_idle();

    // zero key length with junk in the upper bits, all-ones key, unused registers
    write_reg(rc4_pkg::REG_KEY_LEN, {ALL_ONES[rc4_pkg::CFG_DATA_W-1:rc4_pkg::KEY_LEN_W], 6'd0});
    write_reg(rc4_pkg::REG_KEY_WORD0, ALL_ONES);
    write_reg(REG_KEY_WORD1, ALL_ONES);
    write_reg(REG_KEY_WORD2, ALL_ONES);
    write_reg(REG_KEY_WORD3, ALL_ONES);
    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_beat(rc4_pkg::REQ_KEY, 8'h00, 1'b0);
    send_data(3);
    wait_idle();

    // key length above the maximum saturates
    write_reg(rc4_pkg::REG_KEY_LEN, 64'd63);
    write_reg(rc4_pkg::REG_KEY_WORD0, {$urandom, $urandom});
    write_reg(REG_KEY_WORD1, {$urandom, $urandom});
    write_reg(REG_KEY_WORD2, {$urandom, $urandom});
    write_reg(REG_KEY_WORD3, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_beat(rc4_pkg::REQ_KEY, 8'h00, 1'b0);
    send_data(3);
    wait_idle();

    write_reg(rc4_pkg::REG_KEY_LEN, 64'd32);
    write_reg(REG_KEY_WORD3, '0);
    cfg_we <= 1'b0;
    send_beat(rc4_pkg::REQ_KEY, 8'hA5, 1'b1);
    send_beat(rc4_pkg::REQ_KEY, 8'h00, 1'b0);
    send_data(2);
    wait_idle();

    while (random_sent < RANDOM_BEATS) begin
      gap_max   = ($urandom_range(3) == 0) ? 0 : 8;
      stall_max = ($urandom_range(3) == 0) ? 0 : 8;
      len_word  = {$urandom, $urandom};
      case ($urandom_range(5))
        0:       len_word[rc4_pkg::KEY_LEN_W-1:0] = 6'd0;
        1:       len_word[rc4_pkg::KEY_LEN_W-1:0] = 6'd1;
        2:       len_word[rc4_pkg::KEY_LEN_W-1:0] = 6'd32;
        3:       len_word[rc4_pkg::KEY_LEN_W-1:0] = 6'd63;
        default: len_word[rc4_pkg::KEY_LEN_W-1:0] = 6'($urandom_range(MAX_KEY_BYTES, 1));
      endcase
      write_reg(rc4_pkg::REG_KEY_LEN, len_word);
      write_reg(rc4_pkg::REG_KEY_WORD0, pick_key_word());
      write_reg(REG_KEY_WORD1, pick_key_word());
      write_reg(REG_KEY_WORD2, pick_key_word());
      write_reg(REG_KEY_WORD3, pick_key_word());
      if ($urandom_range(4) == 0)
        write_reg(rc4_pkg::CFG_ADDR_W'($urandom_range(int'(REG_UNUSED_HI),
                                                      int'(REG_UNUSED_LO))),
                  {$urandom, $urandom});
      cfg_we <= 1'b0;
      // mostly a rekey then a data stream; sometimes carry on with the old state
      if ($urandom_range(9) != 0) begin
        send_beat(rc4_pkg::REQ_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
        random_sent++;
      end
      beats = $urandom_range(140, 60);
      if (beats > RANDOM_BEATS - random_sent) beats = RANDOM_BEATS - random_sent;
      for (int n = 0; n < beats; n++) begin
        if ($urandom_range(49) == 0)
          send_beat(rc4_pkg::REQ_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
          send_beat(rc4_pkg::REQ_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        random_sent++;
      end
      wait_idle();
    end

    repeat (REKEY_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/rc4_pkg.sv
rtl/rc4_ctrl.sv
rtl/rc4_dp.sv
rtl/rc4_keystream_cipher.sv
dv/tb_rc4_keystream_cipher.sv
